FILE: hw/rtl/tgbc_pkg.sv
package tgbc_pkg;

    // request kinds carried on the input tuser
    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_MOVE_X = 2'd1;
    localparam logic [1:0] REQ_MOVE_Y = 2'd2;

    // field widths
    localparam int POS_W   = 24;
    localparam int HALF_W  = 14;
    localparam int TILE_W  = 6;
    localparam int CELL_W  = 7;
    localparam int IN_W    = 104;
    localparam int OUT_W   = 56;
    localparam int REQ_W   = 2;

    localparam logic [CELL_W-1:0] CELL_SIZE_RESET = 7'd16;

    // controller to datapath
    typedef struct packed {
        logic clear_en;
        logic tile_wr;
        logic load;
        logic prep;
        logic div_step;
        logic scan_init;
        logic rd;
        logic step;
        logic snap;
        logic load_out;
    } tgbc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic delta_zero;
        logic div_done;
        logic span_empty;
        logic solid;
        logic scan_last;
    } tgbc_status_t;

endpackage

FILE: hw/rtl/tile_grid_box_collision.sv
// Tile grid box collision, one axis per move.
// Input stream: s_tuser carries the request kind (write tile, move x, move y),
// s_tdata the box, displacement and tile fields. A write transfer updates one
// tile of the blocked map and gives no result; a move transfer gives exactly one
// result transfer on the master side with the resolved centre and a hit flag.
// The cell size register is written through cfg_wr_en / cfg_wr_data; the user
// must write it only while idle, which the block itself does not enforce.
// The four floor divisions run as parallel restoring lanes, one quotient bit a
// cycle; the scan then reads the map memory one tile at a time, with a read
// state and then a check state for each tile. A zero move skips the divisions
// and the scan. Items are handled one at a time; a write transfer is taken in
// the idle state without leaving it. After reset the map is swept to walkable,
// during which s_tready stays low; cell size returns to 16.
// The result sits in an output register: a stalled receiver holds it there
// while the next input transfer is still taken, and a further move waits
// only for that register to drain.
module tile_grid_box_collision #(
    parameter int MAP_COLS  = 64,
    parameter int MAP_ROWS  = 64,
    parameter int FRAC_BITS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [tgbc_pkg::CELL_W-1:0]  cfg_wr_data,  // cell_size
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // pos_x, pos_y, delta, half_size, tile_col, tile_row, tile_blocked, zero pad
    input  logic [tgbc_pkg::IN_W-1:0]    s_tdata,
    input  logic [tgbc_pkg::REQ_W-1:0]   s_tuser,      // req_type
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // new_pos_x, new_pos_y, hit, zero pad
    output logic [tgbc_pkg::OUT_W-1:0]   m_tdata
);
    import tgbc_pkg::*;

    tgbc_cmd_t    cmd;
    tgbc_status_t st;

    // sequencer
    tgbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // map, dividers and scan
    tgbc_datapath #(
        .MAP_COLS  (MAP_COLS),
        .MAP_ROWS  (MAP_ROWS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cmd         (cmd),
        .st          (st),
        .m_tdata     (m_tdata)
    );

endmodule

FILE: hw/rtl/tgbc_datapath.sv
module tgbc_datapath #(
    parameter int MAP_COLS  = 64,
    parameter int MAP_ROWS  = 64,
    parameter int FRAC_BITS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [tgbc_pkg::CELL_W-1:0]  cfg_wr_data,
    input  logic [tgbc_pkg::IN_W-1:0]    s_tdata,
    input  logic [tgbc_pkg::REQ_W-1:0]   s_tuser,
    input  tgbc_pkg::tgbc_cmd_t          cmd,
    output tgbc_pkg::tgbc_status_t       st,
    output logic [tgbc_pkg::OUT_W-1:0]   m_tdata
);
    import tgbc_pkg::*;

    localparam int DEPTH = MAP_COLS * MAP_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MW    = 26;
    localparam int DW    = MW - 1 - FRAC_BITS;
    localparam int QW    = DW + 1;
    localparam int CW    = $clog2(DW + 1);
    localparam int PW    = QW + 1 + CELL_W + 1;
    localparam int SW    = PW + FRAC_BITS + 2;

    // input field unpack
    logic signed [POS_W-1:0]  in_px, in_py, in_d;
    logic        [HALF_W-1:0] in_h;
    logic        [TILE_W-1:0] in_col, in_row;
    logic                     in_blk;

    assign in_px  = s_tdata[23:0];
    assign in_py  = s_tdata[47:24];
    assign in_d   = s_tdata[71:48];
    assign in_h   = s_tdata[85:72];
    assign in_col = s_tdata[91:86];
    assign in_row = s_tdata[97:92];
    assign in_blk = s_tdata[98];

    // cell size register
    logic [CELL_W-1:0] cs_reg;
    logic [CELL_W-1:0] cs_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cs_reg <= CELL_SIZE_RESET;
        else if (cfg_wr_en)
            cs_reg <= cfg_wr_data;
    end

    assign cs_eff = (cs_reg == '0) ? CELL_W'(1) : cs_reg;

    // item registers
    logic signed [POS_W-1:0]  px_reg, py_reg, d_reg;
    logic        [HALF_W-1:0] h_reg;
    logic                     ax_reg;
    logic signed [MW-1:0]     mv_reg, cr_reg;
    logic                     dpos;

    assign dpos = !d_reg[POS_W-1];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            px_reg <= in_px;
            py_reg <= in_py;
            d_reg  <= in_d;
            h_reg  <= in_h;
            ax_reg <= (s_tuser == REQ_MOVE_X);
        end
    end

    // moved and cross axis positions
    logic signed [MW-1:0] mv_new, cr_new, h_ext;
    logic signed [MW-1:0] edge_val [4];

    assign mv_new = ax_reg ? (MW'(px_reg) + MW'(d_reg)) : (MW'(py_reg) + MW'(d_reg));
    assign cr_new = ax_reg ? MW'(py_reg) : MW'(px_reg);
    assign h_ext  = $signed(MW'(h_reg));
    assign edge_val[0] = mv_new - h_ext;
    assign edge_val[1] = mv_new + h_ext - MW'(1);
    assign edge_val[2] = cr_new - h_ext;
    assign edge_val[3] = cr_new + h_ext - MW'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            mv_reg <= mv_new;
            cr_reg <= cr_new;
        end
    end

    // four floor-division lanes, one quotient bit a cycle
    logic [DW-1:0]     dq_reg  [4];
    logic [CELL_W-1:0] rem_reg [4];
    logic              neg_reg [4];
    logic [CW-1:0]     dcnt_reg;
    logic signed [QW-1:0] quo [4];

    always_ff @(posedge clk)
    begin
        logic signed [MW-1:0] v;
        logic [CELL_W:0] rs;
        for (int i = 0; i < 4; i++)
        begin
            v = edge_val[i] >>> FRAC_BITS;
            rs = {rem_reg[i], dq_reg[i][DW-1]};
            if (cmd.prep)
            begin
                neg_reg[i] <= v[MW-1];
                dq_reg[i]  <= v[MW-1] ? DW'(~v) : DW'(v);
                rem_reg[i] <= '0;
            end
            else if (cmd.div_step)
            begin
                if (rs >= {1'b0, cs_eff})
                begin
                    rem_reg[i] <= CELL_W'(rs - {1'b0, cs_eff});
                    dq_reg[i]  <= {dq_reg[i][DW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i] <= rs[CELL_W-1:0];
                    dq_reg[i]  <= {dq_reg[i][DW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dcnt_reg <= '0;
        else if (cmd.prep)
            dcnt_reg <= '0;
        else if (cmd.div_step)
            dcnt_reg <= dcnt_reg + CW'(1);
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            quo[i] = neg_reg[i] ? ~$signed({1'b0, dq_reg[i]}) : $signed({1'b0, dq_reg[i]});
    end

    // tile scan counters
    logic signed [QW-1:0] lead_reg, crs_reg;
    logic signed [QW-1:0] lead_end;
    logic signed [QW-1:0] tcol, trow;
    logic                 oob;

    assign lead_end = dpos ? quo[1] : quo[0];
    assign tcol = ax_reg ? lead_reg : crs_reg;
    assign trow = ax_reg ? crs_reg : lead_reg;
    assign oob  = (int'(tcol) < 0) || (int'(tcol) >= MAP_COLS) ||
                  (int'(trow) < 0) || (int'(trow) >= MAP_ROWS);

    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            lead_reg <= dpos ? quo[0] : quo[1];
            crs_reg  <= quo[2];
        end
        else if (cmd.step)
        begin
            if (crs_reg == quo[3])
            begin
                crs_reg  <= quo[2];
                lead_reg <= dpos ? (lead_reg + QW'(1)) : (lead_reg - QW'(1));
            end
            else
                crs_reg <= crs_reg + QW'(1);
        end
    end

    // tile map with clearing sweep
    logic          mem [DEPTH];
    logic          mem_q;
    logic          oob_reg;
    logic [AW-1:0] clr_reg;
    logic [AW-1:0] wr_addr, rd_addr, wa;
    logic          we, wd, wr_in_map;

    assign wr_in_map = (int'(in_col) < MAP_COLS) && (int'(in_row) < MAP_ROWS);
    assign wr_addr   = AW'(int'(in_row) * MAP_COLS + int'(in_col));
    assign rd_addr   = AW'(int'(trow) * MAP_COLS + int'(tcol));
    assign we = cmd.clear_en || (cmd.tile_wr && wr_in_map);
    assign wa = cmd.clear_en ? clr_reg : wr_addr;
    assign wd = cmd.clear_en ? 1'b0 : in_blk;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (cmd.clear_en)
            clr_reg <= clr_reg + AW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (cmd.rd)
        begin
            mem_q   <= mem[rd_addr];
            oob_reg <= oob;
        end
    end

    // snap against the near edge of the blocked tile
    logic signed [PW-1:0] prod_reg;
    logic                 hit_reg;
    logic signed [QW:0]   snap_tile;

    assign snap_tile = dpos ? (QW+1)'(lead_reg) : ((QW+1)'(lead_reg) + (QW+1)'(1));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            hit_reg <= 1'b0;
        else if (cmd.snap)
        begin
            hit_reg  <= 1'b1;
            prod_reg <= PW'(snap_tile * $signed({1'b0, cs_eff}));
        end
    end

    // result and saturation
    logic signed [SW-1:0] scaled, fin;
    logic [POS_W-1:0]     sat;
    logic [OUT_W-1:0]     out_reg;

    assign scaled = SW'(prod_reg) <<< FRAC_BITS;

    always_comb
    begin
        if (!hit_reg)
            fin = SW'(mv_reg);
        else if (dpos)
            fin = scaled - $signed(SW'(h_reg));
        else
            fin = scaled + $signed(SW'(h_reg));
        if (fin[SW-1:POS_W-1] == '0 || fin[SW-1:POS_W-1] == '1)
            sat = fin[POS_W-1:0];
        else
            sat = fin[SW-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg[23:0]  <= ax_reg ? sat : px_reg;
            out_reg[47:24] <= ax_reg ? py_reg : sat;
            out_reg[48]    <= hit_reg;
            out_reg[55:49] <= '0;
        end
    end

    assign m_tdata = out_reg;

    // status
    assign st.clear_last = (clr_reg == AW'(DEPTH - 1));
    assign st.delta_zero = (d_reg == '0);
    assign st.div_done   = (dcnt_reg == CW'(DW - 1));
    assign st.span_empty = (quo[0] > quo[1]) || (quo[2] > quo[3]);
    assign st.solid      = oob_reg || mem_q;
    assign st.scan_last  = (crs_reg == quo[3]) && (lead_reg == lead_end);

endmodule

FILE: hw/rtl/tgbc_ctrl.sv
module tgbc_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    input  logic [tgbc_pkg::REQ_W-1:0]   s_tuser,
    output logic                         s_tready,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    input  tgbc_pkg::tgbc_status_t       st,
    output tgbc_pkg::tgbc_cmd_t          cmd
);
    import tgbc_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_PREP  = 9'b000000100,
        S_DIV   = 9'b000001000,
        S_INIT  = 9'b000010000,
        S_RD    = 9'b000100000,
        S_CHK   = 9'b001000000,
        S_SNAP  = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   ovalid_reg, ovalid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        ovalid_next = ovalid_reg && !m_tready;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (st.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    case (s_tuser)
                        REQ_WRITE:
                            cmd.tile_wr = 1'b1;
                        REQ_MOVE_X, REQ_MOVE_Y:
                        begin
                            cmd.load   = 1'b1;
                            state_next = S_PREP;
                        end
                        default:
                            ;
                    endcase
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = st.delta_zero ? S_OUT : S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_done)
                    state_next = S_INIT;
            end
            S_INIT:
            begin
                cmd.scan_init = 1'b1;
                state_next    = st.span_empty ? S_OUT : S_RD;
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (st.solid)
                    state_next = S_SNAP;
                else if (st.scan_last)
                    state_next = S_OUT;
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_RD;
                end
            end
            S_SNAP:
            begin
                cmd.snap   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    cmd.load_out = 1'b1;
                    ovalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_CLEAR;
        endcase
    end

    assign m_tvalid = ovalid_reg;

endmodule

FILE: bench/tile_grid_box_collision_tb.sv
`timescale 1ns / 1ps

module tile_grid_box_collision_tb;
    import tgbc_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int MAP_N = 64;
    localparam int STALL_LIMIT = 200000;
    localparam longint POS_MAX = 8388607;
    localparam longint POS_MIN = -8388608;

    typedef struct {
        logic [1:0]         req;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [23:0] d;
        logic [13:0]        h;
        logic [5:0]         col;
        logic [5:0]         row;
        logic               blk;
    } req_t;

    typedef struct {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic               hit;
    } pos_t;

    // row kinds of the directed table
    typedef enum int { ROW_PREDICT, ROW_TYPED, ROW_SILENT } row_kind_t;

    typedef struct {
        req_t      it;
        row_kind_t kind;
        pos_t      want;
    } dir_row_t;

    logic                clk = 0;
    logic                rst_n = 0;
    logic                cfg_wr_en = 0;
    logic [CELL_W-1:0]   cfg_wr_data = '0;
    logic                s_tvalid = 0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata = '0;
    logic [REQ_W-1:0]    s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 0;
    logic [OUT_W-1:0]    m_tdata;

    tile_grid_box_collision uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #1 clk = ~clk;

    // model state
    bit          tile_map [0:MAP_N*MAP_N-1];
    logic [6:0]  cell_q = CELL_SIZE_RESET;
    pos_t        pending_pos [$];
    dir_row_t    dir_tab [$];

    int errors = 0;
    int moves_sent = 0;
    int writes_sent = 0;
    int results_seen = 0;
    int hits_seen = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_left = 0;
    bit hold_req = 0;
    int stall_cnt = 0;

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch on %s: got %0d, expected %0d (result %0d)",
                 what, got, want, results_seen);
    endtask

    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q -= 1;
        return q;
    endfunction

    function automatic bit tile_solid(longint c, longint r);
        if (c < 0 || r < 0 || c >= MAP_N || r >= MAP_N)
            return 1;
        return tile_map[r * MAP_N + c];
    endfunction

    function automatic logic signed [23:0] sat_pos(longint v);
        if (v > POS_MAX) v = POS_MAX;
        if (v < POS_MIN) v = POS_MIN;
        return v[23:0];
    endfunction

    // predicts one transfer; writes update the map, moves give a result
    function automatic bit resolve_move(req_t it, output pos_t r);
        longint px, py, d, h, cell_len, mv, cr, mlo, mhi, clo, chi, t, k;
        bit along_x, hit, solid;
        px = it.px; py = it.py; d = it.d; h = it.h;
        hit = 0;
        r = '{x: '0, y: '0, hit: 0};
        if (it.req == REQ_WRITE) begin
            tile_map[{it.row, it.col}] = it.blk;
            return 0;
        end
        if (it.req == REQ_UNUSED)
            return 0;
        along_x = (it.req == REQ_MOVE_X);
        if (d != 0) begin
            cell_len = longint'(cell_q == 0 ? 7'd1 : cell_q) << 8;
            if (along_x) begin px += d; mv = px; cr = py; end
            else begin py += d; mv = py; cr = px; end
            mlo = floor_div(mv - h, cell_len);
            mhi = floor_div(mv + h - 1, cell_len);
            clo = floor_div(cr - h, cell_len);
            chi = floor_div(cr + h - 1, cell_len);
            t = (d > 0) ? mlo : mhi;
            while (!hit && t >= mlo && t <= mhi) begin
                solid = 0;
                for (k = clo; k <= chi && !solid; k++)
                    solid = along_x ? tile_solid(t, k) : tile_solid(k, t);
                if (solid) begin
                    mv = (d > 0) ? t * cell_len - h : (t + 1) * cell_len + h;
                    hit = 1;
                end
                t = (d > 0) ? t + 1 : t - 1;
            end
            if (along_x) px = mv; else py = mv;
        end
        r.x = sat_pos(px);
        r.y = sat_pos(py);
        r.hit = hit;
        return 1;
    endfunction

    // offers one transfer, keeping valid high across back-to-back items
    task automatic send_req(req_t it, bit typed, bit typed_res, pos_t want);
        pos_t r;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser  <= it.req;
        s_tdata  <= {5'd0, it.blk, it.row, it.col, it.h, it.d, it.py, it.px};
        do @(posedge clk); while (!s_tready);
        if (resolve_move(it, r)) begin
            if (!typed)
                pending_pos.push_back(r);
        end
        if (typed && typed_res)
            pending_pos.push_back(want);
        if (it.req == REQ_WRITE) writes_sent++;
        else if (it.req != REQ_UNUSED) moves_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 0;
        while (pending_pos.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_cell(logic [6:0] v);
        cfg_wr_en   <= 1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 0;
        cell_q = v;
        @(posedge clk);
    endtask

    function automatic req_t rand_req();
        req_t it;
        longint cs, span, px, py, d, h;
        int pick;
        cs = (cell_q == 0) ? 1 : cell_q;
        span = MAP_N * cs * 256;
        pick = $urandom_range(99);
        it.req = (pick < 30) ? REQ_WRITE : (pick < 33) ? REQ_UNUSED :
                 (pick < 66) ? REQ_MOVE_X : REQ_MOVE_Y;
        it.col = 6'($urandom); it.row = 6'($urandom);
        it.blk = ($urandom_range(99) < 60);
        px = longint'($urandom_range(0, 32'(span + 2 * cs * 256))) - cs * 256;
        py = longint'($urandom_range(0, 32'(span + 2 * cs * 256))) - cs * 256;
        d  = longint'($urandom_range(0, 32'(6 * cs * 256))) - 3 * cs * 256;
        h  = longint'($urandom_range(0, (2 * cs * 256 > 4000) ? 4000 : 32'(2 * cs * 256)));
        pick = $urandom_range(99);
        if (pick < 5) begin
            px = longint'($signed(24'($urandom)));
            py = longint'($signed(24'($urandom)));
        end
        else if (pick < 10) d = longint'($signed(24'($urandom)));
        else if (pick < 14) d = 0;
        else if (pick < 17 && cs >= 8) h = longint'($urandom_range(0, 16383));
        it.px = px[23:0]; it.py = py[23:0]; it.d = d[23:0]; it.h = h[13:0];
        return it;
    endfunction

    task automatic add_row(logic [1:0] req, int px, int py, int d, int h,
                           int col, int row, int blk, row_kind_t kind,
                           int wx, int wy, int whit);
        dir_row_t dr;
        dr.it = '{req: req, px: px[23:0], py: py[23:0], d: d[23:0], h: h[13:0],
                  col: col[5:0], row: row[5:0], blk: blk[0]};
        dr.kind = kind;
        dr.want = '{x: wx[23:0], y: wy[23:0], hit: whit[0]};
        dir_tab.push_back(dr);
    endtask

    // result checking and receiver back-pressure
    always @(posedge clk) begin
        pos_t w;
        if (m_tvalid && m_tready) begin
            results_seen++;
            if (pending_pos.size() == 0) begin
                errors++;
                $display("result transfer with nothing expected");
            end else begin
                w = pending_pos.pop_front();
                if (m_tdata[23:0] !== w.x)
                    report_mismatch("new_pos_x", $signed(m_tdata[23:0]), w.x);
                if (m_tdata[47:24] !== w.y)
                    report_mismatch("new_pos_y", $signed(m_tdata[47:24]), w.y);
                if (m_tdata[48] !== w.hit)
                    report_mismatch("hit", m_tdata[48], w.hit);
                if (m_tdata[48]) hits_seen++;
            end
        end
        if (hold_req) begin
            hold_left = 400;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 0;
        end else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // watchdog on cycles with no transfer at all
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cnt <= 0;
        else if (stall_cnt >= STALL_LIMIT) begin
            $display("tile_grid_box_collision_tb: errors");
            $finish;
        end else
            stall_cnt <= stall_cnt + 1;
    end

    initial begin
        logic [6:0] cell_plan [6];
        pos_t none;
        int n;
        cell_plan = '{7'd16, 7'd1, 7'd64, 7'd0, 7'd127, 7'd7};
        none = '{x: '0, y: '0, hit: 0};
        foreach (tile_map[i]) tile_map[i] = 0;

        // directed table, cell size 16 after reset
        add_row(REQ_MOVE_X, 1000, 2000, 0, 300, 0, 0, 0, ROW_TYPED, 1000, 2000, 0);
        add_row(REQ_UNUSED, 1000, 2000, 512, 300, 1, 1, 1, ROW_SILENT, 0, 0, 0);
        add_row(REQ_MOVE_X, 8388607, 0, 1, 0, 0, 0, 0, ROW_TYPED, 8388607, 0, 0);
        add_row(REQ_MOVE_Y, 5, -8388608, -1, 0, 0, 0, 0, ROW_TYPED, 5, -8388608, 1);
        add_row(REQ_MOVE_X, 1024, 25600, -2048, 512, 0, 0, 0, ROW_TYPED, 512, 25600, 1);
        add_row(REQ_WRITE, 0, 0, 0, 0, 5, 5, 1, ROW_PREDICT, 0, 0, 0);
        add_row(REQ_MOVE_X, 15360, 22528, 5120, 1024, 0, 0, 0, ROW_PREDICT, 0, 0, 0);
        add_row(REQ_MOVE_X, 30720, 22528, -10240, 1024, 0, 0, 0, ROW_PREDICT, 0, 0, 0);
        add_row(REQ_MOVE_Y, 22528, 15360, 5120, 1024, 0, 0, 0, ROW_PREDICT, 0, 0, 0);
        add_row(REQ_MOVE_Y, 22528, 30720, -10240, 1024, 0, 0, 0, ROW_PREDICT, 0, 0, 0);
        add_row(REQ_WRITE, 0, 0, 0, 0, 63, 63, 1, ROW_PREDICT, 0, 0, 0);
        add_row(REQ_MOVE_X, 254000, 259000, 4000, 2000, 0, 0, 0, ROW_PREDICT, 0, 0, 0);
        add_row(REQ_WRITE, 0, 0, 0, 0, 5, 5, 0, ROW_PREDICT, 0, 0, 0);
        add_row(REQ_MOVE_X, 15360, 22528, 5120, 1024, 0, 0, 0, ROW_PREDICT, 0, 0, 0);
        add_row(REQ_MOVE_Y, 100000, 100000, 3000, 16383, 0, 0, 0, ROW_PREDICT, 0, 0, 0);
        add_row(REQ_MOVE_X, 0, 0, 8388607, 100, 0, 0, 0, ROW_PREDICT, 0, 0, 0);
        add_row(REQ_MOVE_Y, 0, 0, -8388608, 100, 0, 0, 0, ROW_PREDICT, 0, 0, 0);
        add_row(REQ_WRITE, 0, 0, 0, 0, 0, 0, 0, ROW_PREDICT, 0, 0, 0);
        add_row(REQ_MOVE_Y, -1, -1, 77, 3, 0, 0, 0, ROW_PREDICT, 0, 0, 0);

        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_req(dir_tab[i].it, dir_tab[i].kind != ROW_PREDICT,
                     dir_tab[i].kind == ROW_TYPED, dir_tab[i].want);
        drain_results();

        // random phases over the cell size settings
        n = 0;
        foreach (cell_plan[p]) begin
            write_cell(cell_plan[p]);
            for (int k = 0; k < 80; k++) begin
                if (n < 160) begin tx_idle_pct = 35; rx_idle_pct = 75; end
                else if (n < 320) begin tx_idle_pct = 75; rx_idle_pct = 35; end
                else begin tx_idle_pct = 0; rx_idle_pct = 0; end
                if (p == 2 && k == 10)
                    hold_req = 1;
                send_req(rand_req(), 0, 0, none);
                n++;
            end
            drain_results();
        end

        $display("sent %0d moves and %0d tile writes over %0d cell sizes",
                 moves_sent, writes_sent, 6);
        $display("checked %0d results, %0d of them stopped by a tile",
                 results_seen, hits_seen);
        if (errors == 0 && pending_pos.size() == 0)
            $display("tile_grid_box_collision_tb: clean");
        else
            $display("tile_grid_box_collision_tb: errors");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/tgbc_pkg.sv
hw/rtl/tgbc_datapath.sv
hw/rtl/tgbc_ctrl.sv
hw/rtl/tile_grid_box_collision.sv
bench/tile_grid_box_collision_tb.sv
